// ===== hw/rtl/frar_pkg.sv =====
// ----------------------------------------------------------------------------
// frar_pkg: shared types and constants for fraction arithmetic with reduction
// Operand widths, derived datapath widths, request/response structs,
// command codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frar_pkg;

    localparam int OPERAND_WIDTH = 16;

    // fixed result field widths
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 31;

    // derived datapath widths
    localparam int PROD_W = 2 * OPERAND_WIDTH;   // one signed product
    localparam int NUMS_W = PROD_W + 1;          // signed sum of two products
    localparam int MAG_W  = PROD_W;              // magnitude of num or den
    localparam int SUB_W  = MAG_W + 1;           // shared subtractor width
    localparam int CNT_W  = $clog2(MAG_W);       // divide steps / gcd shift

    typedef logic signed [OPERAND_WIDTH-1:0] t_opnd;
    typedef logic signed [PROD_W-1:0]        t_prod;
    typedef logic signed [NUMS_W-1:0]        t_nums;
    typedef logic        [MAG_W-1:0]         t_mag;
    typedef logic        [SUB_W-1:0]         t_sub;
    typedef logic        [CNT_W-1:0]         t_cnt;
    typedef logic signed [NUM_W-1:0]         t_num;
    typedef logic        [DEN_W-1:0]         t_den;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] command;
        t_opnd      a_numerator;
        t_opnd      a_denominator;
        t_opnd      b_numerator;
        t_opnd      b_denominator;
    } t_req;

    typedef struct packed {
        t_num result_numerator;
        t_den result_denominator;
        logic divide_error;
    } t_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/frar_sub.sv =====
// ----------------------------------------------------------------------------
// frar_sub: shared subtractor
// Unsigned subtract with borrow out; serves both the gcd compare/subtract
// steps and the restoring divide steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frar_sub (
    input  wire frar_pkg::t_sub i_minuend,
    input  wire frar_pkg::t_sub i_subtrahend,
    output frar_pkg::t_sub      o_diff,
    output logic                o_borrow
);

    assign {o_borrow, o_diff} = {1'b0, i_minuend} - {1'b0, i_subtrahend};

endmodule

`default_nettype wire

// ===== hw/rtl/fraction_arithmetic_reduce.sv =====
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce: rational add/sub/mul/div reduced to lowest terms
// Sequence: a request taken in idle passes the three multiply states, the sum
//   state, the binary gcd loop and the numerator and denominator divides.
//   Zero denominators go from idle to done, zero results from sum to done.
// Throughput: one request at a time; the next is taken once the sequencer is
//   back in idle.
// Reset: synchronous active low, clears sequencer and result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fraction_arithmetic_reduce (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // request channel
    input  wire                 i_req_valid,
    output logic                o_req_stall,
    input  wire frar_pkg::t_req i_req,
    // response channel
    output logic                o_rsp_valid,
    input  wire                 i_rsp_stall,
    output frar_pkg::t_rsp      o_rsp
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    frar_pkg::t_state r_state, n_state;
    frar_pkg::t_cmd   r_cmd,   n_cmd;
    frar_pkg::t_opnd  r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic             r_err,  n_err;      // zero denominator seen
    logic             r_zero, n_zero;     // numerator came out zero
    logic             r_neg,  n_neg;      // sign of the result
    frar_pkg::t_prod  r_p0, n_p0, r_p1, n_p1, r_p2, n_p2;
    frar_pkg::t_mag   r_un, n_un;         // |num|, later num / g
    frar_pkg::t_mag   r_ud, n_ud;         // |den|, later den / g
    frar_pkg::t_mag   r_x,  n_x;          // gcd working pair
    frar_pkg::t_mag   r_y,  n_y;
    frar_pkg::t_cnt   r_k,  n_k;          // common factors of two
    frar_pkg::t_mag   r_g,  n_g;          // gcd
    frar_pkg::t_mag   r_rem, n_rem;       // divide partial remainder
    frar_pkg::t_cnt   r_cnt, n_cnt;       // divide step count
    logic             r_out_valid, n_out_valid;
    frar_pkg::t_rsp   r_out, n_out;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    frar_pkg::t_opnd  mul_a, mul_b;
    frar_pkg::t_prod  mul_p;
    frar_pkg::t_sub   sub_a, sub_b, sub_diff;
    logic             sub_borrow;

    // sum stage terms
    frar_pkg::t_nums  num_s, den_s;
    logic             num_neg, den_neg;
    frar_pkg::t_mag   mag_n, mag_d;

    // divide helpers
    frar_pkg::t_mag   div_src;
    frar_pkg::t_sub   rem_sh;

    logic             out_load;

    // one signed multiplier; its product always lands in a register
    assign mul_p = frar_pkg::t_prod'(mul_a) * frar_pkg::t_prod'(mul_b);

    frar_sub u_sub (
        .i_minuend    (sub_a),
        .i_subtrahend (sub_b),
        .o_diff       (sub_diff),
        .o_borrow     (sub_borrow)
    );

    // ------------------------------------------------------------------
    // Sum / sign / magnitude of the cross products
    // ------------------------------------------------------------------
    always_comb begin
        case (r_cmd)
            frar_pkg::CMD_ADD: num_s = frar_pkg::t_nums'(r_p0) + frar_pkg::t_nums'(r_p1);
            frar_pkg::CMD_SUB: num_s = frar_pkg::t_nums'(r_p0) - frar_pkg::t_nums'(r_p1);
            default:           num_s = frar_pkg::t_nums'(r_p0);
        endcase
        den_s   = (r_cmd == frar_pkg::CMD_DIV) ? frar_pkg::t_nums'(r_p1)
                                               : frar_pkg::t_nums'(r_p2);
        num_neg = num_s[frar_pkg::NUMS_W-1];
        den_neg = den_s[frar_pkg::NUMS_W-1];
        mag_n   = frar_pkg::t_mag'(num_neg ? -num_s : num_s);
        mag_d   = frar_pkg::t_mag'(den_neg ? -den_s : den_s);
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_an    = r_an;
        n_ad    = r_ad;
        n_bn    = r_bn;
        n_bd    = r_bd;
        n_err   = r_err;
        n_zero  = r_zero;
        n_neg   = r_neg;
        n_p0    = r_p0;
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_un    = r_un;
        n_ud    = r_ud;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_g     = r_g;
        n_rem   = r_rem;
        n_cnt   = r_cnt;

        mul_a   = r_an;
        mul_b   = r_bd;
        sub_a   = '0;
        sub_b   = '0;

        // dividend shifts out of the top while quotient bits enter below
        div_src = (r_state == frar_pkg::ST_DIVD) ? r_ud : r_un;
        rem_sh  = {r_rem, div_src[frar_pkg::MAG_W-1]};

        unique case (r_state)
            frar_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_cmd  = frar_pkg::t_cmd'(i_req.command);
                    n_an   = i_req.a_numerator;
                    n_ad   = i_req.a_denominator;
                    n_bn   = i_req.b_numerator;
                    n_bd   = i_req.b_denominator;
                    n_zero = 1'b0;
                    n_err  = (i_req.a_denominator == '0) || (i_req.b_denominator == '0) ||
                             ((frar_pkg::t_cmd'(i_req.command) == frar_pkg::CMD_DIV) &&
                              (i_req.b_numerator == '0));
                    n_state = n_err ? frar_pkg::ST_DONE : frar_pkg::ST_MUL0;
                end
            end

            frar_pkg::ST_MUL0: begin
                mul_a   = r_an;
                mul_b   = (r_cmd == frar_pkg::CMD_MUL) ? r_bn : r_bd;
                n_p0    = mul_p;
                n_state = frar_pkg::ST_MUL1;
            end

            frar_pkg::ST_MUL1: begin
                mul_a   = r_ad;
                mul_b   = r_bn;
                n_p1    = mul_p;
                n_state = frar_pkg::ST_MUL2;
            end

            frar_pkg::ST_MUL2: begin
                mul_a   = r_ad;
                mul_b   = r_bd;
                n_p2    = mul_p;
                n_state = frar_pkg::ST_SUM;
            end

            frar_pkg::ST_SUM: begin
                n_un    = mag_n;
                n_ud    = mag_d;
                n_x     = mag_n;
                n_y     = mag_d;
                n_k     = '0;
                n_neg   = num_neg ^ den_neg;
                n_zero  = (num_s == '0);
                n_state = n_zero ? frar_pkg::ST_DONE : frar_pkg::ST_GCD;
            end

            // binary gcd: strip twos, then subtract odd from odd
            frar_pkg::ST_GCD: begin
                sub_a = frar_pkg::t_sub'(r_x);
                sub_b = frar_pkg::t_sub'(r_y);
                if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (sub_borrow) begin
                    n_x = r_y;
                    n_y = r_x;
                end else if (sub_diff == '0) begin
                    n_g     = frar_pkg::t_mag'(r_y << r_k);
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = frar_pkg::ST_DIVN;
                end else begin
                    n_x = frar_pkg::t_mag'(sub_diff >> 1);
                end
            end

            // restoring divide, one quotient bit a cycle
            frar_pkg::ST_DIVN: begin
                sub_a = rem_sh;
                sub_b = frar_pkg::t_sub'(r_g);
                n_rem = sub_borrow ? rem_sh[frar_pkg::MAG_W-1:0]
                                   : sub_diff[frar_pkg::MAG_W-1:0];
                n_un  = {r_un[frar_pkg::MAG_W-2:0], ~sub_borrow};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == frar_pkg::t_cnt'(frar_pkg::MAG_W - 1)) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = frar_pkg::ST_DIVD;
                end
            end

            frar_pkg::ST_DIVD: begin
                sub_a = rem_sh;
                sub_b = frar_pkg::t_sub'(r_g);
                n_rem = sub_borrow ? rem_sh[frar_pkg::MAG_W-1:0]
                                   : sub_diff[frar_pkg::MAG_W-1:0];
                n_ud  = {r_ud[frar_pkg::MAG_W-2:0], ~sub_borrow};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == frar_pkg::t_cnt'(frar_pkg::MAG_W - 1)) begin
                    n_cnt   = '0;
                    n_state = frar_pkg::ST_DONE;
                end
            end

            frar_pkg::ST_DONE: begin
                if (!r_out_valid || !i_rsp_stall) begin
                    n_state = frar_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = frar_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register: frees the sequencer while the result waits
    // ------------------------------------------------------------------
    always_comb begin
        out_load = (r_state == frar_pkg::ST_DONE) && (!r_out_valid || !i_rsp_stall);
        n_out    = r_out;
        if (out_load) begin
            if (r_err) begin
                n_out.result_numerator   = '0;
                n_out.result_denominator = '0;
                n_out.divide_error       = 1'b1;
            end else if (r_zero) begin
                n_out.result_numerator   = '0;
                n_out.result_denominator = frar_pkg::t_den'(1);
                n_out.divide_error       = 1'b0;
            end else begin
                n_out.result_numerator   = r_neg ? ('0 - frar_pkg::t_num'(r_un))
                                                 : frar_pkg::t_num'(r_un);
                n_out.result_denominator = frar_pkg::t_den'(r_ud);
                n_out.divide_error       = 1'b0;
            end
        end
        n_out_valid = out_load | (r_out_valid & i_rsp_stall);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frar_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_an   <= n_an;
        r_ad   <= n_ad;
        r_bn   <= n_bn;
        r_bd   <= n_bd;
        r_err  <= n_err;
        r_zero <= n_zero;
        r_neg  <= n_neg;
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_un   <= n_un;
        r_ud   <= n_ud;
        r_x    <= n_x;
        r_y    <= n_y;
        r_k    <= n_k;
        r_g    <= n_g;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

    assign o_req_stall = (r_state != frar_pkg::ST_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

// ===== bench/fraction_arithmetic_reduce_test.sv =====
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce_test: self-checking bench for fraction arithmetic
// Sends fraction pairs with add/sub/mul/div commands through the request
// channel, predicts each reduced result and checks every response against it,
// with random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fraction_arithmetic_reduce_test;

    // generous: worst case is ~1400 requests x (full sequence + long gap + long stall)
    localparam int CYCLE_LIMIT = 1_200_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    frar_pkg::t_req i_req = '0;
    logic i_rsp_stall = 1'b0;
    logic o_req_stall;
    logic o_rsp_valid;
    frar_pkg::t_rsp o_rsp;

    // expected reduced fractions, oldest first
    frar_pkg::t_rsp expected_fractions[$];

    // idling controls, set per test
    logic req_gaps_on = 1'b0;
    logic rsp_stalls_on = 1'b0;
    int stall_left = 0;

    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int sent_by_cmd[4] = '{0, 0, 0, 0};
    int sent_errors = 0;

    fraction_arithmetic_reduce u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp      (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction: cross-multiply, push the sign into the numerator, then
    // divide both terms by the gcd of their magnitudes.
    // ------------------------------------------------------------------------
    function automatic frar_pkg::t_rsp reduce_fraction(frar_pkg::t_req r);
        frar_pkg::t_rsp res;
        longint an, ad, bn, bd, num, den, reduced;
        longint unsigned un, ud, x, y, rem;
        logic neg;
        res = '0;
        an = longint'(r.a_numerator);
        ad = longint'(r.a_denominator);
        bn = longint'(r.b_numerator);
        bd = longint'(r.b_denominator);
        // zero operand denominator, or a quotient by a zero fraction
        if (ad == 0 || bd == 0 ||
            (frar_pkg::t_cmd'(r.command) == frar_pkg::CMD_DIV && bn == 0)) begin
            res.divide_error = 1'b1;
            return res;
        end
        case (frar_pkg::t_cmd'(r.command))
            frar_pkg::CMD_ADD: begin
                num = an * bd + ad * bn;
                den = ad * bd;
            end
            frar_pkg::CMD_SUB: begin
                num = an * bd - ad * bn;
                den = ad * bd;
            end
            frar_pkg::CMD_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        // zero result is always 0/1
        if (num == 0) begin
            res.result_denominator = frar_pkg::t_den'(1);
            return res;
        end
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        x = un;
        y = ud;
        while (y != 0) begin
            rem = x % y;
            x = y;
            y = rem;
        end
        un = un / x;
        ud = ud / x;
        reduced = neg ? -longint'(un) : longint'(un);
        res.result_numerator = reduced[frar_pkg::NUM_W-1:0];
        res.result_denominator = ud[frar_pkg::DEN_W-1:0];
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic frar_pkg::t_req make_pair(frar_pkg::t_cmd cmd, int an, int ad,
                                                 int bn, int bd);
        frar_pkg::t_req r;
        r.command = cmd;
        r.a_numerator = frar_pkg::t_opnd'(an);
        r.a_denominator = frar_pkg::t_opnd'(ad);
        r.b_numerator = frar_pkg::t_opnd'(bn);
        r.b_denominator = frar_pkg::t_opnd'(bd);
        return r;
    endfunction

    function automatic frar_pkg::t_opnd boundary_operand();
        case ($urandom_range(0, 6))
            0: return frar_pkg::t_opnd'(-32768);
            1: return frar_pkg::t_opnd'(-32767);
            2: return frar_pkg::t_opnd'(-1);
            3: return frar_pkg::t_opnd'(0);
            4: return frar_pkg::t_opnd'(1);
            5: return frar_pkg::t_opnd'(16384);
            default: return frar_pkg::t_opnd'(32767);
        endcase
    endfunction

    function automatic frar_pkg::t_opnd small_operand();
        return frar_pkg::t_opnd'(int'($urandom_range(0, 128)) - 64);
    endfunction

    // Mix of full-range pairs, small pairs (lots of common factors),
    // boundary values, zero denominators and zero numerators.
    function automatic frar_pkg::t_req random_fraction_pair();
        frar_pkg::t_req r;
        int unsigned mode;
        mode = $urandom_range(0, 99);
        r = frar_pkg::t_req'({$urandom, $urandom, $urandom});
        r.command = 2'($urandom_range(0, 3));
        if (mode >= 55 && mode < 80) begin
            r.a_numerator = small_operand();
            r.a_denominator = small_operand();
            r.b_numerator = small_operand();
            r.b_denominator = small_operand();
        end else if (mode >= 80 && mode < 90) begin
            r.a_numerator = boundary_operand();
            r.a_denominator = boundary_operand();
            r.b_numerator = boundary_operand();
            r.b_denominator = boundary_operand();
        end else if (mode >= 90 && mode < 95) begin
            if ($urandom_range(0, 1)) r.a_denominator = '0;
            else r.b_denominator = '0;
        end else if (mode >= 95) begin
            if ($urandom_range(0, 1)) begin
                r.command = frar_pkg::CMD_DIV;
                r.b_numerator = '0;
            end else begin
                r.a_numerator = '0;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: optional gap, then hold the request until accepted.
    // Valid only drops when a gap is taken, so it never toggles in one step.
    // ------------------------------------------------------------------------
    task automatic send_fraction_pair(input frar_pkg::t_req item);
        int gap;
        frar_pkg::t_rsp predicted;
        gap = req_gaps_on ? gap_length() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req <= item;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (o_req_stall);
        predicted = reduce_fraction(item);
        expected_fractions.push_back(predicted);
        sent_by_cmd[item.command]++;
        if (predicted.divide_error) sent_errors++;
    endtask

    // Response stall: bursts of random length when enabled
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_rsp_stall <= 1'b1;
        end else if (rsp_stalls_on && $urandom_range(0, 99) < 30) begin
            stall_left <= gap_length();
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= 1'b0;
        end
    end

    // Response checker: every accepted response against the oldest prediction
    always @(posedge i_clk) begin
        frar_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (expected_fractions.size() == 0) begin
                $error("response with nothing outstanding: num %0d den %0d err %0b",
                       o_rsp.result_numerator, o_rsp.result_denominator,
                       o_rsp.divide_error);
                mismatches++;
            end else begin
                want = expected_fractions.pop_front();
                results_checked++;
                if (o_rsp.result_numerator !== want.result_numerator) begin
                    $error("result_numerator: expected %0d, got %0d",
                           want.result_numerator, o_rsp.result_numerator);
                    mismatches++;
                end
                if (o_rsp.result_denominator !== want.result_denominator) begin
                    $error("result_denominator: expected %0d, got %0d",
                           want.result_denominator, o_rsp.result_denominator);
                    mismatches++;
                end
                if (o_rsp.divide_error !== want.divide_error) begin
                    $error("divide_error: expected %0b, got %0b",
                           want.divide_error, o_rsp.divide_error);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, expected_fractions.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Each command, operand extremes, zero denominators, quotient by a zero
    // fraction, zero results and negative denominators.
    task automatic test_directed_cases();
        frar_pkg::t_req cases[$];
        cases.push_back(make_pair(frar_pkg::CMD_ADD, 1, 2, 1, 3));
        cases.push_back(make_pair(frar_pkg::CMD_SUB, 1, 2, 1, 3));
        cases.push_back(make_pair(frar_pkg::CMD_MUL, 2, 3, 3, 4));
        cases.push_back(make_pair(frar_pkg::CMD_DIV, 2, 3, 4, 9));
        cases.push_back(make_pair(frar_pkg::CMD_ADD, -32768, -32768, -32768, -32768));
        cases.push_back(make_pair(frar_pkg::CMD_ADD, -32768, 32767, 32767, -32768));
        cases.push_back(make_pair(frar_pkg::CMD_MUL, -32768, 1, -32768, 1));
        cases.push_back(make_pair(frar_pkg::CMD_MUL, 32767, -32768, 32767, -32768));
        cases.push_back(make_pair(frar_pkg::CMD_DIV, -32768, 1, 1, -32768));
        // largest denominator
        cases.push_back(make_pair(frar_pkg::CMD_DIV, 1, -32768, -32768, 1));
        cases.push_back(make_pair(frar_pkg::CMD_SUB, 32767, 1, -32768, 1));
        cases.push_back(make_pair(frar_pkg::CMD_ADD, 5, 0, 1, 2));   // a denominator zero
        cases.push_back(make_pair(frar_pkg::CMD_MUL, 1, 2, 3, 0));   // b denominator zero
        cases.push_back(make_pair(frar_pkg::CMD_SUB, 7, 0, 9, 0));
        cases.push_back(make_pair(frar_pkg::CMD_DIV, 3, 4, 0, 5));   // divide by zero fraction
        cases.push_back(make_pair(frar_pkg::CMD_DIV, 0, 1, 0, 7));
        cases.push_back(make_pair(frar_pkg::CMD_ADD, 1, 2, -1, 2));  // zero results
        cases.push_back(make_pair(frar_pkg::CMD_SUB, 3, 4, 6, 8));
        cases.push_back(make_pair(frar_pkg::CMD_MUL, 0, -5, 7, 3));
        cases.push_back(make_pair(frar_pkg::CMD_DIV, 0, 3, 5, 7));
        cases.push_back(make_pair(frar_pkg::CMD_ADD, 0, -32768, 0, 32767));
        cases.push_back(make_pair(frar_pkg::CMD_ADD, 1, -3, 1, -6)); // negative denominators
        cases.push_back(make_pair(frar_pkg::CMD_MUL, -1, -1, -1, -1));
        cases.push_back(make_pair(frar_pkg::CMD_DIV, 7, -1, -7, 1));
        cases.push_back(make_pair(frar_pkg::CMD_SUB, -32768, -1, 32767, 1));
        req_gaps_on = 1'b0;
        rsp_stalls_on = 1'b0;
        foreach (cases[i]) send_fraction_pair(cases[i]);
    endtask

    // Requests back to back, receiver always ready
    task automatic test_back_to_back();
        req_gaps_on = 1'b0;
        rsp_stalls_on = 1'b0;
        repeat (200) send_fraction_pair(random_fraction_pair());
    endtask

    // Gaps and stalls on both sides, so they land on every sequencer phase
    task automatic test_random_idling();
        req_gaps_on = 1'b1;
        rsp_stalls_on = 1'b1;
        repeat (1000) send_fraction_pair(random_fraction_pair());
    endtask

    // Eager sender against a slow receiver
    task automatic test_stalled_receiver();
        req_gaps_on = 1'b0;
        rsp_stalls_on = 1'b1;
        repeat (125) send_fraction_pair(random_fraction_pair());
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_back_to_back();
        test_random_idling();
        test_stalled_receiver();

        @(negedge i_clk);
        i_req_valid <= 1'b0;
        rsp_stalls_on = 1'b0;
        while (expected_fractions.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Requests: %0d add, %0d sub, %0d mul, %0d div; %0d hit a zero denominator",
                 sent_by_cmd[frar_pkg::CMD_ADD], sent_by_cmd[frar_pkg::CMD_SUB],
                 sent_by_cmd[frar_pkg::CMD_MUL], sent_by_cmd[frar_pkg::CMD_DIV],
                 sent_errors);
        $display("Responses checked: %0d, field mismatches: %0d, cycles: %0d",
                 results_checked, mismatches, cycle_count);
        if (mismatches == 0 && expected_fractions.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
